// ===== hw/rtl/dsq_pkg.sv =====
// Shared types, constants and helper functions of the depth sort queue.
// Holds widths of the distance datapath and the circular-store address math.
// No dependencies.
`default_nettype none

package dsq_pkg;

    localparam int CAPACITY   = 512;
    localparam int COORD_BITS = 19;

    localparam int CAM_W    = 20;
    localparam int HANDLE_W = 16;
    localparam int DIST_W   = 46;
    localparam int OP_W     = 2;
    localparam int CFG_A_W  = 2;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);

    // distance datapath widths
    localparam int S_W   = COORD_BITS + 2;
    localparam int D_W   = ((CAM_W + 1 > S_W) ? CAM_W + 1 : S_W) + 1;
    localparam int AD_W  = D_W - 1;
    localparam int SQ_W  = 2 * AD_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int EXT_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    localparam int ENTRY_W = DIST_W + HANDLE_W;

    localparam int IN_DATA_W  = ((HANDLE_W + 9 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((HANDLE_W + DIST_W + 7) / 8) * 8;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [CFG_A_W-1:0] {
        REG_CAM_X = 2'd0,
        REG_CAM_Y = 2'd1,
        REG_CAM_Z = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SRCH,
        ST_CMP,
        ST_SHIFT,
        ST_PLACE,
        ST_POP
    } state_t;

    // clamp a sum of squares to the distance field
    function automatic logic [DIST_W-1:0] dist_sat(input logic [SUM_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        if (e > EXT_W'(DIST_MAX))
            return DIST_MAX;
        return DIST_W'(e);
    endfunction

    // physical slot of logical offset b from slot a, wrapping at CAPACITY
    function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
                                                   input logic [FILL_W-1:0] b);
        logic [FILL_W:0] s;
        s = (FILL_W + 1)'(a) + (FILL_W + 1)'(b);
        if (s >= (FILL_W + 1)'(CAPACITY))
            s = s - (FILL_W + 1)'(CAPACITY);
        return ADDR_W'(s);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
        if (a == ADDR_W'(CAPACITY - 1))
            return '0;
        return a + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_dec(input logic [ADDR_W-1:0] a);
        if (a == '0)
            return ADDR_W'(CAPACITY - 1);
        return a - ADDR_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dsq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/depth_sort_queue.sv =====
// Top level of the depth sort queue: distance datapath, sorted circular store.
// Depends on dsq_pkg and dsq_ram.
//
// Usage:
//   Input stream (s_axis_*): tuser carries the op (insert, pop, clear), tdata the
//   handle, box corners and origin. Output stream (m_axis_*): one item per pop,
//   tdata = handle and squared distance, tuser = empty flag.
//   Configuration: cfg_we/cfg_addr/cfg_wdata write camera x, y, z (index 0..2);
//   write them only while the block is idle.
// Operation:
//   Pop: one RAM read of the head entry as the pop is accepted; the result is
//   registered once the result register is free. Clear and a dropped insert
//   (store full) return straight to idle. Insert: squares (ST_MUL), clamped
//   sum (ST_SUM), a binary search over the stored items with one read per step
//   on the single RAM port (ST_SRCH, ST_CMP), one entry moved per cycle toward
//   the nearer end of the circular store (ST_SHIFT), then the write (ST_PLACE).
// Reset: the store is empty, camera at the origin; no RAM clearing pass is needed.
// Stall: the result register holds until m_axis_tready; a new item is still
//   accepted meanwhile, and a following pop waits for the register to free up.
`default_nettype none

module depth_sort_queue (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // tdata: handle, box_min_x/y/z, box_max_x/y/z, pos_x/y/z, zero pad
    input  wire logic [dsq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: op
    input  wire logic [dsq_pkg::OP_W-1:0]           s_axis_tuser,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: out_handle, dist_sq, zero pad
    output logic      [dsq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tuser: empty_res
    output logic      [0:0]                         m_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic                               cfg_we,
    input  wire logic [dsq_pkg::CFG_A_W-1:0]        cfg_addr,
    input  wire logic [dsq_pkg::CAM_W-1:0]          cfg_wdata
);

    import dsq_pkg::*;

    state_t state_reg, state_next;

    logic signed [CAM_W-1:0] cam_reg [3];

    logic [FILL_W-1:0] fill_reg;
    logic [ADDR_W-1:0] head_reg;

    // binary search bounds and shift count
    logic [FILL_W-1:0] lo_reg, hi_reg, cnt_reg;
    logic [FILL_W:0]   mid_sum;
    logic [FILL_W-1:0] mid;
    logic [FILL_W-1:0] tail_cnt;
    logic              go_front;

    // insert payload
    logic [AD_W-1:0]     ad_reg [3];
    logic [SQ_W-1:0]     sq_reg [3];
    logic [DIST_W-1:0]   dist_reg;
    logic [HANDLE_W-1:0] handle_reg;

    // entry move pipeline
    logic              front_reg;
    logic [ADDR_W-1:0] cur_reg;
    logic [ADDR_W-1:0] place_addr_reg;
    logic              pend_valid_reg;
    logic [ADDR_W-1:0] pend_addr_reg;

    // result register
    logic                pop_empty_reg;
    logic                out_valid_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic                out_empty_reg;
    logic                out_free;

    // RAM port
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [DIST_W-1:0]  rd_dist;

    // input decode
    logic                         s_accept;
    op_t                          in_op;
    logic [HANDLE_W-1:0]          in_handle;
    logic signed [COORD_BITS-1:0] coord [9];
    logic signed [S_W-1:0]        s_w [3];
    logic signed [D_W-1:0]        d_w [3];
    logic [D_W-1:0]               dabs_w [3];
    logic [SUM_W-1:0]             sum_w;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign in_op     = op_t'(s_axis_tuser);
    assign in_handle = s_axis_tdata[HANDLE_W-1:0];
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign rd_dist   = ram_rdata[ENTRY_W-1 -: DIST_W];

    assign mid_sum  = (FILL_W + 1)'(lo_reg) + (FILL_W + 1)'(hi_reg);
    assign mid      = mid_sum[FILL_W:1];
    assign tail_cnt = fill_reg - lo_reg;
    assign go_front = lo_reg < tail_cnt;

    // Per axis: twice the camera minus (min + max + 2*pos), then its magnitude.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            coord[k] = s_axis_tdata[HANDLE_W + k * COORD_BITS +: COORD_BITS];
        for (int a = 0; a < 3; a++)
        begin
            s_w[a]    = S_W'(coord[a]) + S_W'(coord[3 + a]) + (S_W'(coord[6 + a]) <<< 1);
            d_w[a]    = (D_W'(cam_reg[a]) <<< 1) - D_W'(s_w[a]);
            dabs_w[a] = d_w[a][D_W-1] ? D_W'(-d_w[a]) : D_W'(d_w[a]);
        end
    end

    assign sum_w = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    dsq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (in_op)
                        OP_INSERT:
                            if (fill_reg != FILL_W'(CAPACITY))
                                state_next = ST_MUL;
                        OP_POP:
                            state_next = ST_POP;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_SRCH;
            ST_SRCH:  state_next = (lo_reg == hi_reg) ? ST_SHIFT : ST_CMP;
            ST_CMP:   state_next = ST_SRCH;
            ST_SHIFT:
                if (cnt_reg == '0)
                    state_next = ST_PLACE;
            ST_PLACE:
                if (!pend_valid_reg)
                    state_next = ST_IDLE;
            ST_POP:
                if (out_free)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake and RAM port
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = head_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ram_re        = s_axis_tvalid && (in_op == OP_POP);
                ram_raddr     = head_reg;
            end
            ST_SRCH:
            begin
                ram_re    = lo_reg != hi_reg;
                ram_raddr = addr_add(head_reg, mid);
            end
            ST_SHIFT:
            begin
                ram_re    = cnt_reg != '0;
                ram_raddr = cur_reg;
            end
            default:
            begin
                ram_re    = 1'b0;
                ram_raddr = head_reg;
            end
        endcase

        // a pending move write has priority over placing the new entry
        ram_we    = pend_valid_reg || (state_reg == ST_PLACE);
        ram_waddr = pend_valid_reg ? pend_addr_reg : place_addr_reg;
        ram_wdata = pend_valid_reg ? ram_rdata : {dist_reg, handle_reg};
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cam_reg[0]     <= '0;
            cam_reg[1]     <= '0;
            cam_reg[2]     <= '0;
            fill_reg       <= '0;
            head_reg       <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_CAM_X: cam_reg[0] <= cfg_wdata;
                    REG_CAM_Y: cam_reg[1] <= cfg_wdata;
                    REG_CAM_Z: cam_reg[2] <= cfg_wdata;
                    default:   ;
                endcase
            end

            pend_valid_reg <= (state_reg == ST_SHIFT) && (cnt_reg != '0);

            // load a new result, else drop the one taken by the receiver
            if (state_reg == ST_POP && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                    if (s_accept && in_op == OP_CLEAR)
                    begin
                        fill_reg <= '0;
                        head_reg <= '0;
                    end
                ST_SUM:
                begin
                    lo_reg <= '0;
                    hi_reg <= fill_reg;
                end
                ST_SRCH:
                    if (lo_reg == hi_reg)
                    begin
                        // move the shorter side: front entries shift toward a new head
                        cnt_reg <= go_front ? lo_reg : tail_cnt;
                        if (go_front)
                            head_reg <= addr_dec(head_reg);
                    end
                ST_CMP:
                    if (rd_dist >= dist_reg)
                        lo_reg <= mid + FILL_W'(1);
                    else
                        hi_reg <= mid;
                ST_SHIFT:
                    if (cnt_reg != '0)
                        cnt_reg <= cnt_reg - FILL_W'(1);
                ST_PLACE:
                    if (!pend_valid_reg)
                        fill_reg <= fill_reg + FILL_W'(1);
                ST_POP:
                    if (out_free)
                    begin
                        if (!pop_empty_reg)
                        begin
                            head_reg <= addr_inc(head_reg);
                            fill_reg <= fill_reg - FILL_W'(1);
                        end
                    end
                default: ;
            endcase
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (s_accept)
                begin
                    handle_reg    <= in_handle;
                    pop_empty_reg <= fill_reg == '0;
                    for (int a = 0; a < 3; a++)
                        ad_reg[a] <= AD_W'(dabs_w[a]);
                end
            ST_MUL:
                for (int a = 0; a < 3; a++)
                    sq_reg[a] <= ad_reg[a] * ad_reg[a];
            ST_SUM:
                dist_reg <= dist_sat(sum_w);
            ST_SRCH:
                if (lo_reg == hi_reg)
                begin
                    front_reg <= go_front;
                    if (go_front)
                    begin
                        cur_reg        <= head_reg;
                        place_addr_reg <= addr_add(addr_dec(head_reg), lo_reg);
                    end
                    else
                    begin
                        cur_reg        <= addr_add(head_reg, fill_reg - FILL_W'(1));
                        place_addr_reg <= addr_add(head_reg, lo_reg);
                    end
                end
            ST_SHIFT:
                if (cnt_reg != '0)
                begin
                    // the entry read now lands one slot over, written next cycle
                    cur_reg       <= front_reg ? addr_inc(cur_reg) : addr_dec(cur_reg);
                    pend_addr_reg <= front_reg ? addr_dec(cur_reg) : addr_inc(cur_reg);
                end
            ST_POP:
                if (out_free)
                begin
                    out_empty_reg  <= pop_empty_reg;
                    out_handle_reg <= pop_empty_reg ? '0 : ram_rdata[HANDLE_W-1:0];
                    out_dist_reg   <= pop_empty_reg ? '0 : rd_dist;
                end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_dist_reg, out_handle_reg});
    assign m_axis_tuser  = out_empty_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("store fill count above capacity");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP && out_free && !pop_empty_reg)
        |=> fill_reg == $past(fill_reg) - FILL_W'(1))
        else $error("pop of a stored entry did not shrink the store");

    a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_POP)
        else $error("result raised outside a pop");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata == '0)
        else $error("empty pop result carries data");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/depth_sort_queue_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of depth_sort_queue: streams insert, pop, clear and ignored
// items, predicts every pop result with a farthest-first object store and checks it.
// Depends on dsq_pkg and the depth_sort_queue RTL.

module depth_sort_queue_tb;

    import dsq_pkg::*;

    // index with no register behind it; a write there must change nothing
    localparam logic [CFG_A_W-1:0] REG_UNUSED = 2'd3;
    // op code the block must ignore
    localparam logic [OP_W-1:0]    OP_UNUSED  = 2'd3;

    localparam logic [COORD_BITS-1:0] COORD_MAX = COORD_BITS'((1 << (COORD_BITS - 1)) - 1);
    localparam logic [COORD_BITS-1:0] COORD_MIN = COORD_BITS'(1 << (COORD_BITS - 1));
    localparam logic [CAM_W-1:0]      CAM_MAX   = CAM_W'((1 << (CAM_W - 1)) - 1);
    localparam logic [CAM_W-1:0]      CAM_MIN   = CAM_W'(1 << (CAM_W - 1));

    // time for the slowest insert, at a nearly full store, to finish; allow margin
    localparam int SETTLE_CYCLES = 320;
    localparam int STALL_LIMIT   = 5000;
    localparam int FILL_INSERTS  = CAPACITY + 4;

    // coordinates in tdata order: box_min x/y/z, box_max x/y/z, pos x/y/z
    typedef struct packed {
        logic [OP_W-1:0]                 op;
        logic [HANDLE_W-1:0]             handle;
        logic [8:0][COORD_BITS-1:0]      crd;
    } item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [DIST_W-1:0]   dist_sq;
    } object_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [DIST_W-1:0]   dist_sq;
        logic                empty;
    } pop_result_t;

    // Farthest-first store of objects plus the pop results still owed by the block.
    class depth_order_model;
        logic signed [CAM_W-1:0] cam [3];
        object_t                 stored [$];
        pop_result_t             owed_pops [$];
        int                      errors = 0;

        function void set_camera(logic [CFG_A_W-1:0] idx, logic [CAM_W-1:0] v);
            case (idx)
                REG_CAM_X: cam[0] = v;
                REG_CAM_Y: cam[1] = v;
                REG_CAM_Z: cam[2] = v;
                default: ;
            endcase
        endfunction

        // twice the box centre plus origin against twice the camera, per axis
        function logic [DIST_W-1:0] squared_distance(item_t it);
            longint centre2;
            longint delta;
            longint total;
            total = 0;
            for (int a = 0; a < 3; a++)
            begin
                centre2 = longint'($signed(it.crd[a])) + longint'($signed(it.crd[a + 3]))
                        + 2 * longint'($signed(it.crd[a + 6]));
                delta = 2 * longint'(cam[a]) - centre2;
                total += delta * delta;
            end
            if (total > longint'(DIST_MAX))
                return DIST_MAX;
            return total[DIST_W-1:0];
        endfunction

        function void note_item(item_t it);
            object_t     obj;
            pop_result_t res;
            int          slot;
            case (it.op)
                OP_INSERT:
                begin
                    // full store: drop silently
                    if (stored.size() < CAPACITY)
                    begin
                        obj.handle  = it.handle;
                        obj.dist_sq = squared_distance(it);
                        // go behind every object at least as far, so ties keep arrival order
                        slot = 0;
                        while (slot < stored.size() && stored[slot].dist_sq >= obj.dist_sq)
                            slot++;
                        stored.insert(slot, obj);
                    end
                end
                OP_POP:
                begin
                    if (stored.size() == 0)
                    begin
                        res.handle  = '0;
                        res.dist_sq = '0;
                        res.empty   = 1'b1;
                    end
                    else
                    begin
                        obj         = stored.pop_front();
                        res.handle  = obj.handle;
                        res.dist_sq = obj.dist_sq;
                        res.empty   = 1'b0;
                    end
                    owed_pops.push_back(res);
                end
                OP_CLEAR: stored.delete();
                default: ;
            endcase
        endfunction

        function void check_result(logic [HANDLE_W-1:0] handle, logic [DIST_W-1:0] dist_sq,
                                   logic empty);
            pop_result_t exp;
            if (owed_pops.size() == 0)
            begin
                $error("result item with no pop outstanding: handle %0h dist_sq %0h", handle,
                       dist_sq);
                errors++;
                return;
            end
            exp = owed_pops.pop_front();
            if (handle !== exp.handle)
            begin
                $error("out_handle: expected %0h, got %0h", exp.handle, handle);
                errors++;
            end
            if (dist_sq !== exp.dist_sq)
            begin
                $error("dist_sq: expected %0h, got %0h", exp.dist_sq, dist_sq);
                errors++;
            end
            if (empty !== exp.empty)
            begin
                $error("empty_res: expected %0b, got %0b", exp.empty, empty);
                errors++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic [OP_W-1:0]         s_axis_tuser;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [0:0]              m_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic                    cfg_we;
    logic [CFG_A_W-1:0]      cfg_addr;
    logic [CAM_W-1:0]        cfg_wdata;

    depth_order_model sb;
    int               send_idle = 19;   // percent of cycles the sender holds off
    int               recv_idle = 57;   // percent of cycles the receiver stalls
    int               stalled   = 0;

    depth_sort_queue i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Receiver: check each accepted result item, then pick the next ready level.
    // Signals are read right after the edge, so they hold their pre-edge values.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[HANDLE_W-1:0], m_axis_tdata[HANDLE_W +: DIST_W],
                            m_axis_tuser[0]);
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            stalled <= 0;
        else
            stalled <= stalled + 1;
        if (stalled >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_item(item_t it);
        logic [IN_DATA_W-1:0] p;
        p = '0;
        p[HANDLE_W-1:0] = it.handle;
        for (int k = 0; k < 9; k++)
            p[HANDLE_W + k * COORD_BITS +: COORD_BITS] = it.crd[k];
        return p;
    endfunction

    function automatic item_t make_item(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] handle,
                                        int v);
        item_t it;
        it.op     = op;
        it.handle = handle;
        for (int k = 0; k < 9; k++)
            it.crd[k] = v[COORD_BITS-1:0];
        return it;
    endfunction

    // full range, a narrow band around zero (many equal distances), or an extreme
    function automatic logic [COORD_BITS-1:0] rand_coord(int kind);
        int near;
        if (kind < 4)
            return COORD_BITS'($urandom);
        if (kind < 8)
        begin
            near = int'($urandom_range(8)) - 4;
            return near[COORD_BITS-1:0];
        end
        return $urandom_range(1) ? COORD_MAX : COORD_MIN;
    endfunction

    function automatic item_t rand_insert();
        item_t it;
        int    kind;
        kind      = $urandom_range(9);
        it.op     = OP_INSERT;
        it.handle = HANDLE_W'($urandom);
        for (int k = 0; k < 9; k++)
            it.crd[k] = rand_coord(kind);
        return it;
    endfunction

    // Offer one item, holding it until accepted. tvalid stays high after the
    // handshake so a back-to-back item needs only one assignment in that step.
    task automatic send_item(item_t it);
        if ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_item(it);
        s_axis_tuser  <= it.op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_item(it);
    endtask

    // Drop tvalid and hold until every owed pop result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.owed_pops.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then let a trailing insert finish before touching the registers.
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CAM_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        sb.set_camera(idx, v);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_camera(logic [CAM_W-1:0] x, logic [CAM_W-1:0] y,
                              logic [CAM_W-1:0] z);
        write_reg(REG_CAM_X, x);
        write_reg(REG_CAM_Y, y);
        write_reg(REG_CAM_Z, z);
    endtask

    // Mostly inserts so the store grows deep; pops, a rare clear and ignored
    // items carry random payload as noise.
    task automatic run_mixed(int count);
        item_t it;
        int    r;
        for (int n = 0; n < count; n++)
        begin
            r  = $urandom_range(999);
            it = rand_insert();
            if (r >= 600)
                it.op = (r < 970) ? OP_POP : (r < 985) ? OP_CLEAR : OP_UNUSED;
            send_item(it);
        end
    endtask

    initial
    begin
        item_t it;
        sb = new;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: sender idles a little, receiver a lot. Camera at the origin.
        set_camera('0, '0, '0);
        write_reg(REG_UNUSED, CAM_W'($urandom));

        // pop on an empty store, then an item with the unused op code
        send_item(make_item(OP_POP, '0, 0));
        send_item(make_item(OP_UNUSED, '1, -1));
        // coordinate extremes, handle extremes, and three equal distances
        send_item(make_item(OP_INSERT, 16'h0000, int'(COORD_MIN)));
        send_item(make_item(OP_INSERT, 16'hffff, int'(COORD_MAX)));
        send_item(make_item(OP_INSERT, 16'h0001, 0));
        send_item(make_item(OP_INSERT, 16'h0002, 0));
        it        = make_item(OP_INSERT, 16'h0003, 0);
        it.crd[0] = '1;
        it.crd[3] = COORD_BITS'(1);
        send_item(it);
        it        = make_item(OP_INSERT, 16'h8000, 0);
        it.crd[6] = COORD_MAX;
        send_item(it);
        repeat (4)
            send_item(make_item(OP_POP, '0, 0));
        // clear with objects still stored, then find the store empty
        send_item(make_item(OP_CLEAR, '0, 0));
        send_item(make_item(OP_POP, '0, 0));
        it        = make_item(OP_INSERT, 16'h5a5a, 7);
        it.crd[0] = COORD_BITS'(-5);
        it.crd[3] = COORD_BITS'(100);
        it.crd[6] = COORD_MIN;
        send_item(it);
        send_item(make_item(OP_POP, '0, 0));
        send_item(make_item(OP_POP, '0, 0));

        run_mixed(75);
        // hold the sender off until every result is back
        wait_drained();
        run_mixed(75);

        // Phase 2: roles swapped. Camera at its far corner; fill past capacity so
        // the last inserts are dropped, then take some objects out.
        settle();
        set_camera(CAM_MAX, CAM_MAX, CAM_MAX);
        send_idle = 57;
        recv_idle = 19;
        send_item(make_item(OP_CLEAR, HANDLE_W'($urandom), 0));
        repeat (FILL_INSERTS)
            send_item(rand_insert());
        repeat (20)
            send_item(make_item(OP_POP, HANDLE_W'($urandom), 0));
        run_mixed(60);

        // Phase 3: no idling. Camera at the opposite corner, then a random spot.
        settle();
        set_camera(CAM_MIN, CAM_MIN, CAM_MIN);
        send_idle = 0;
        recv_idle = 0;
        send_item(make_item(OP_CLEAR, '0, 0));
        run_mixed(65);
        settle();
        set_camera(CAM_W'($urandom), CAM_W'($urandom), CAM_W'($urandom));
        run_mixed(65);

        settle();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dsq_pkg.sv
hw/rtl/dsq_ram.sv
hw/rtl/depth_sort_queue.sv
tb/sv/depth_sort_queue_tb.sv
